[src/mqtm_pkg.sv]
// package for the multi-queue thread manager
// types and codes shared by controller, datapath and top level; no dependencies
package mqtm_pkg;
    localparam int unsigned HandleW   = 16;
    localparam int unsigned CountW    = 7;
    // fixed by the 2-bit selector and the 7-bit counts
    localparam int unsigned NumQueues = 4;
    localparam int unsigned PoolSize  = 64;

    typedef enum logic [1:0] {
        FUNC_ENQ  = 2'd0,
        FUNC_DEQ  = 2'd1,
        FUNC_PEEK = 2'd2,
        FUNC_LOOK = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        RC_OK       = 2'd0,
        RC_FULL     = 2'd1,
        RC_EMPTY    = 2'd2,
        RC_NOTFOUND = 2'd3
    } t_rc;

    typedef struct packed {
        logic [1:0]         func;
        logic [1:0]         queue_sel;
        logic [HandleW-1:0] tcb_handle;
        logic [HandleW-1:0] tid;
    } t_in_word;

    typedef struct packed {
        logic [1:0]         result_code;
        logic [HandleW-1:0] out_handle;
        logic [CountW-1:0]  queue_count;
    } t_out_word;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture request, select first node
        logic read;     // issue read of current node
        logic step;     // follow link to next node, issue read
        logic commit;   // apply enqueue or dequeue, build result
        logic fail;     // build not-found / refusal / empty result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] func;
        logic       refuse;   // enqueue refused or selector out of range
        logic       empty;
        logic       match;    // current node matches
        logic       stop;     // null handle or walk exhausted
    } t_stat;
endpackage

[src/mqtm_ram.sv]
// generic single-port-write, one-read ram with registered read
// no dependencies
module mqtm_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

[src/mqtm_datapath.sv]
// datapath: queue pointers, free list, node memories, result register
// uses mqtm_pkg and mqtm_ram
module mqtm_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mqtm_pkg::t_in_word  i_word,
    input  logic [6:0]          i_max,
    input  mqtm_pkg::t_cmd      i_cmd,
    output mqtm_pkg::t_stat     o_stat,
    output mqtm_pkg::t_out_word o_word
);
    import mqtm_pkg::*;
    localparam int unsigned PW = $clog2(PoolSize);
    localparam int unsigned QW = $clog2(NumQueues);
    localparam int unsigned FW = $clog2(PoolSize + 1);

    logic [PW-1:0]     r_head [NumQueues];
    logic [PW-1:0]     r_tail [NumQueues];
    logic [CountW-1:0] r_cnt  [NumQueues];
    logic [PW-1:0]     r_free_head;
    logic [FW-1:0]     r_free_cnt;
    // link ram needs no clear: during reset sweep not available, so a fill
    // count marks links never written as the reset chain
    logic [FW-1:0]     r_fill;

    t_in_word          r_req;
    logic              r_qok;
    logic [PW-1:0]     r_node;
    logic [CountW-1:0] r_walk;
    t_out_word         r_out;

    logic [QW-1:0]     q;
    logic [CountW-1:0] cnt;
    logic [PW-1:0]     raddr, n_node;
    logic [HandleW-1:0] rd_h, rd_t;
    logic [PW-1:0]     rd_l_raw, rd_l;
    logic              rd_fresh;
    logic              r_rd_fresh;
    logic [PW-1:0]     r_rd_addr;

    logic              l_we;
    logic [PW-1:0]     l_waddr, l_wdata;
    logic              d_we;

    assign q   = r_req.queue_sel[QW-1:0];
    assign cnt = r_qok ? r_cnt[q] : '0;

    // read address
    always_comb begin
        n_node = r_node;
        if (i_cmd.step) n_node = rd_l;
        raddr = n_node;
    end

    mqtm_ram #(.Width(HandleW), .Depth(PoolSize)) u_h (
        .i_clk, .i_we(d_we), .i_waddr(r_free_head), .i_wdata(r_req.tcb_handle),
        .i_raddr(raddr), .o_rdata(rd_h));
    mqtm_ram #(.Width(HandleW), .Depth(PoolSize)) u_t (
        .i_clk, .i_we(d_we), .i_waddr(r_free_head), .i_wdata(r_req.tid),
        .i_raddr(raddr), .o_rdata(rd_t));
    mqtm_ram #(.Width(PW), .Depth(PoolSize)) u_l (
        .i_clk, .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(raddr), .o_rdata(rd_l_raw));

    always_ff @(posedge i_clk) begin
        r_rd_addr  <= raddr;
        r_rd_fresh <= ({1'b0, raddr} >= r_fill) && !(l_we && l_waddr == raddr);
    end
    assign rd_fresh = r_rd_fresh;
    always_comb begin
        rd_l = rd_l_raw;
        if (rd_fresh)
            rd_l = (FW'(r_rd_addr) + FW'(1) < FW'(PoolSize)) ? PW'(r_rd_addr + 1'b1) : '0;
    end

    wire enq_ok = r_qok && !((i_max != 0) && (cnt >= i_max)) && (r_free_cnt != 0);
    wire is_enq = (r_req.func == FUNC_ENQ);
    wire is_deq = (r_req.func == FUNC_DEQ);

    // link writes for enqueue and dequeue; enqueue: free node read is at r_node = free head via load
    always_comb begin
        l_we = 1'b0; l_waddr = r_free_head; l_wdata = '0;
        d_we = i_cmd.commit && is_enq && enq_ok;
        if (i_cmd.commit && is_enq && enq_ok && cnt != 0) begin
            l_we = 1'b1; l_waddr = r_tail[q]; l_wdata = r_free_head;
        end else if (i_cmd.commit && is_deq) begin
            l_we = 1'b1; l_waddr = r_node; l_wdata = r_free_head;
        end
    end

    assign o_stat.func   = r_req.func;
    assign o_stat.refuse = !r_qok || (is_enq && !enq_ok);
    assign o_stat.empty  = (cnt == 0);
    assign o_stat.match  = (rd_h != 0) && (rd_t == r_req.tid);
    assign o_stat.stop   = (rd_h == 0) || (r_walk + 1'b1 >= cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumQueues; i++) begin
                r_head[i] <= '0; r_tail[i] <= '0; r_cnt[i] <= '0;
            end
            r_free_head <= '0;
            r_free_cnt  <= FW'(PoolSize);
            r_fill      <= '0;
        end else if (i_cmd.commit) begin
            if (is_enq && enq_ok) begin
                // link of the taken node is not written now: it is set when
                // a later enqueue appends to this queue
                r_free_head <= rd_l;
                r_free_cnt  <= r_free_cnt - 1'b1;
                if (cnt == 0) r_head[q] <= r_free_head;
                r_tail[q] <= r_free_head;
                r_cnt[q]  <= cnt + 1'b1;
                if ({1'b0, r_free_head} >= r_fill) r_fill <= FW'(r_free_head) + 1'b1;
            end else if (is_deq && r_qok && cnt != 0) begin
                r_head[q]   <= (cnt == 1) ? '0 : rd_l;
                if (cnt == 1) r_tail[q] <= '0;
                r_cnt[q]    <= cnt - 1'b1;
                r_free_head <= r_node;
                r_free_cnt  <= r_free_cnt + 1'b1;
                if ({1'b0, r_node} >= r_fill) r_fill <= FW'(r_node) + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_word;
            r_qok  <= (32'(i_word.queue_sel) < NumQueues);
            r_walk <= '0;
            r_node <= (i_word.func == FUNC_ENQ) ? r_free_head
                    : r_head[i_word.queue_sel[QW-1:0]];
        end else if (i_cmd.step) begin
            r_node <= n_node;
            r_walk <= r_walk + 1'b1;
        end
        if (i_cmd.commit) begin
            r_out.result_code <= RC_OK;
            r_out.out_handle  <= (is_enq) ? '0 : rd_h;
            r_out.queue_count <= is_enq ? cnt + 1'b1 : (is_deq ? cnt - 1'b1 : cnt);
        end else if (i_cmd.fail) begin
            r_out.out_handle  <= '0;
            r_out.queue_count <= cnt;
            if (!r_qok)         r_out.result_code <= is_enq ? RC_FULL : RC_EMPTY;
            else if (is_enq)    r_out.result_code <= RC_FULL;
            else if (cnt == 0)  r_out.result_code <= RC_EMPTY;
            else                r_out.result_code <= RC_NOTFOUND;
        end
    end
    assign o_word = r_out;
endmodule

[src/mqtm_ctrl.sv]
// controller: request sequencing and output handshake
// uses mqtm_pkg
module mqtm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  mqtm_pkg::t_stat i_stat,
    output mqtm_pkg::t_cmd  o_cmd
);
    import mqtm_pkg::*;
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_EVAL = 5'b00100,
        S_WALK = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;
    t_state r_state, n_state;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: if (i_in_valid) begin
                o_cmd.load = 1'b1; n_state = S_RD;
            end
            S_RD: begin
                o_cmd.read = 1'b1; n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_OUT;
                if (i_stat.refuse || (i_stat.func != FUNC_ENQ && i_stat.empty))
                    o_cmd.fail = 1'b1;
                else if (i_stat.func != FUNC_LOOK || i_stat.match)
                    o_cmd.commit = 1'b1;
                else if (i_stat.stop)
                    o_cmd.fail = 1'b1;
                else begin
                    o_cmd.step = 1'b1; n_state = S_WALK;
                end
            end
            S_WALK: n_state = S_EVAL;   // read data lands next cycle
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

[src/multi_queue_thread_manager.sv]
// channel   dir  handshake                  payload
// in        in   i_in_valid / o_in_ready    mqtm_pkg::t_in_word
// out       out  o_out_valid / i_out_ready  mqtm_pkg::t_out_word
// cfg       in   i_cfg_valid / o_cfg_ready  max_per_queue, 7 bits
// enqueue, dequeue, peek: an accepted word passes S_RD and S_EVAL, then the result is offered in S_OUT
// lookup: each node walked beyond the head adds S_WALK and S_EVAL again, for the link ram read
// one word at a time; next word taken the cycle after the result is taken
// synchronous active-low reset, no clearing pass; output holds while stalled
// top level; uses mqtm_pkg, mqtm_ctrl, mqtm_datapath
module multi_queue_thread_manager (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mqtm_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mqtm_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [6:0]          i_cfg_data
);
    import mqtm_pkg::*;
    logic [6:0] r_max;
    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_max <= '0;
        else if (i_cfg_valid) r_max <= i_cfg_data;
    end

    mqtm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_stat(stat), .o_cmd(cmd));

    mqtm_datapath u_dp (
        .i_clk, .i_rst_n, .i_word(i_in_word), .i_max(r_max), .i_cmd(cmd),
        .o_stat(stat), .o_word(o_out_word));

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cmd)) else $error("multiple commands");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_out_valid && !o_in_ready)
        else $error("accept overlap");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_out_word))
        else $error("result dropped");
endmodule

[tb/sv/multi_queue_thread_manager_test.sv]
// self-checking testbench for the multi-queue thread manager
// directed table, lowered-limit check, then random phases under several queue limits; uses mqtm_pkg and the top level
module multi_queue_thread_manager_test;
    import mqtm_pkg::*;

    localparam int CycleLimit = 1000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_word  o_out_word;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [6:0] i_cfg_data;

    multi_queue_thread_manager i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the queue manager
    logic [5:0] q_head [NumQueues];
    logic [5:0] q_tail [NumQueues];
    logic [6:0] q_count [NumQueues];
    logic [5:0] link [PoolSize];
    logic [15:0] node_hdl [PoolSize];
    logic [15:0] node_tid [PoolSize];
    logic [5:0] free_ptr;
    int         free_left;
    logic [6:0] limit;

    t_out_word  pending_results [$];
    t_out_word  typed_result;
    bit         typed_active;
    bit         calm;
    int         stall_left;
    int         cycles;
    int         errors;
    int         n_checked;
    int         n_full;
    int         n_notfound;

    typedef struct packed {
        t_in_word  word;
        bit        typed;
        t_out_word result;
    } t_row;

    function automatic t_out_word mk(t_rc rc, logic [15:0] h, logic [6:0] c);
        t_out_word r;
        r.result_code = rc;
        r.out_handle  = h;
        r.queue_count = c;
        return r;
    endfunction

    function automatic t_in_word req(t_func f, int q, logic [15:0] h, logic [15:0] t);
        t_in_word w;
        w.func       = f;
        w.queue_sel  = q[1:0];
        w.tcb_handle = h;
        w.tid        = t;
        return w;
    endfunction

    task automatic shadow_reset();
        for (int i = 0; i < NumQueues; i++) begin
            q_head[i] = '0;
            q_tail[i] = '0;
            q_count[i] = '0;
        end
        for (int i = 0; i < PoolSize; i++) begin
            link[i] = 6'((i + 1) % PoolSize);
            node_hdl[i] = '0;
            node_tid[i] = '0;
        end
        free_ptr = '0;
        free_left = PoolSize;
        limit = '0;
    endtask

    function automatic t_out_word queue_op(t_in_word w);
        int         q;
        logic [6:0] cnt;
        logic [5:0] n;
        logic [15:0] h;
        q = w.queue_sel;
        cnt = q_count[q];
        case (t_func'(w.func))
            FUNC_ENQ: begin
                if ((limit != 0 && cnt >= limit) || free_left == 0)
                    return mk(RC_FULL, '0, cnt);
                n = free_ptr;
                free_ptr = link[n];
                free_left--;
                node_hdl[n] = w.tcb_handle;
                node_tid[n] = w.tid;
                link[n] = '0;
                if (cnt == 0) q_head[q] = n;
                else link[q_tail[q]] = n;
                q_tail[q] = n;
                q_count[q] = 7'(cnt + 1);
                return mk(RC_OK, '0, 7'(cnt + 1));
            end
            default: begin
                if (cnt == 0) return mk(RC_EMPTY, '0, '0);
                n = q_head[q];
                if (t_func'(w.func) == FUNC_DEQ) begin
                    h = node_hdl[n];
                    q_head[q] = link[n];
                    q_count[q] = 7'(cnt - 1);
                    if (cnt == 1) begin
                        q_head[q] = '0;
                        q_tail[q] = '0;
                    end
                    link[n] = free_ptr;
                    free_ptr = n;
                    free_left++;
                    return mk(RC_OK, h, 7'(cnt - 1));
                end
                if (t_func'(w.func) == FUNC_PEEK) return mk(RC_OK, node_hdl[n], cnt);
                for (int i = 0; i < cnt; i++) begin
                    if (node_hdl[n] == 0) break;
                    if (node_tid[n] == w.tid) return mk(RC_OK, node_hdl[n], cnt);
                    n = link[n];
                end
                return mk(RC_NOTFOUND, '0, cnt);
            end
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // accepted requests, config writes and results, all sampled at the edge
    always @(posedge i_clk) begin
        t_out_word pred;
        t_out_word want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) limit = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                pred = queue_op(i_in_word);
                pending_results.push_back(typed_active ? typed_result : pred);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, o_out_word);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (want.result_code == RC_FULL) n_full++;
                    if (want.result_code == RC_NOTFOUND) n_notfound++;
                    if (o_out_word.result_code !== want.result_code) begin
                        $display("%0t: result_code expected %0d actual %0d",
                                 $time, want.result_code, o_out_word.result_code);
                        errors++;
                    end
                    if (o_out_word.out_handle !== want.out_handle) begin
                        $display("%0t: out_handle expected %h actual %h",
                                 $time, want.out_handle, o_out_word.out_handle);
                        errors++;
                    end
                    if (o_out_word.queue_count !== want.queue_count) begin
                        $display("%0t: queue_count expected %0d actual %0d",
                                 $time, want.queue_count, o_out_word.queue_count);
                        errors++;
                    end
                end
            end
        end
    end

    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = gap_len();
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    // valid may stay high from the previous word when there is no gap
    task automatic send_word(t_in_word w, bit typed, t_out_word r);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        typed_active <= typed;
        typed_result <= r;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [6:0] v);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_in_word rand_word(int enq_pct);
        t_in_word w;
        int r;
        r = $urandom_range(0, 99);
        if (r < enq_pct) w.func = FUNC_ENQ;
        else w.func = 2'($urandom_range(1, 3));
        w.queue_sel = 2'($urandom_range(0, 3));
        w.tcb_handle = ($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom);
        w.tid = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 7))
                                           : 16'($urandom);
        return w;
    endfunction

    t_row       dir_rows [$];
    logic [6:0] limits [6] = '{7'd0, 7'd64, 7'd1, 7'd3, 7'd0, 7'd17};
    int         enq_bias [6] = '{75, 50, 40, 45, 30, 55};

    initial begin
        t_out_word none;
        none = '0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        typed_active = 1'b0;
        typed_result = '0;
        calm = 1'b0;
        stall_left = 0;
        cycles = 0;
        errors = 0;
        n_checked = 0;
        n_full = 0;
        n_notfound = 0;
        shadow_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queues, extremes, null handles and early stop of the lookup walk
        dir_rows.push_back('{req(FUNC_DEQ, 0, 0, 0), 1, mk(RC_EMPTY, 0, 0)});
        dir_rows.push_back('{req(FUNC_PEEK, 1, 0, 0), 1, mk(RC_EMPTY, 0, 0)});
        dir_rows.push_back('{req(FUNC_LOOK, 2, 0, 0), 1, mk(RC_EMPTY, 0, 0)});
        dir_rows.push_back('{req(FUNC_ENQ, 0, 16'hffff, 0), 1, mk(RC_OK, 0, 1)});
        dir_rows.push_back('{req(FUNC_ENQ, 0, 0, 16'hffff), 1, mk(RC_OK, 0, 2)});
        dir_rows.push_back('{req(FUNC_PEEK, 0, 0, 0), 1, mk(RC_OK, 16'hffff, 2)});
        dir_rows.push_back('{req(FUNC_LOOK, 0, 0, 16'hffff), 1, mk(RC_NOTFOUND, 0, 2)});
        dir_rows.push_back('{req(FUNC_LOOK, 0, 0, 0), 1, mk(RC_OK, 16'hffff, 2)});
        dir_rows.push_back('{req(FUNC_DEQ, 0, 0, 0), 1, mk(RC_OK, 16'hffff, 1)});
        dir_rows.push_back('{req(FUNC_LOOK, 0, 0, 16'hffff), 1, mk(RC_NOTFOUND, 0, 1)});
        dir_rows.push_back('{req(FUNC_DEQ, 0, 0, 0), 1, mk(RC_OK, 0, 0)});
        dir_rows.push_back('{req(FUNC_ENQ, 3, 16'h1234, 5), 1, mk(RC_OK, 0, 1)});
        dir_rows.push_back('{req(FUNC_ENQ, 3, 16'h8000, 7), 0, none});
        dir_rows.push_back('{req(FUNC_LOOK, 3, 0, 7), 0, none});
        dir_rows.push_back('{req(FUNC_LOOK, 3, 0, 9), 1, mk(RC_NOTFOUND, 0, 2)});
        dir_rows.push_back('{req(FUNC_ENQ, 2, 16'h5a5a, 16'ha5a5), 0, none});
        dir_rows.push_back('{req(FUNC_LOOK, 2, 0, 16'ha5a5), 0, none});
        foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed,
                                        dir_rows[i].result);
        typed_active <= 1'b0;

        // limit lowered below the current count of queue 3
        write_limit(7'd1);
        send_word(req(FUNC_ENQ, 3, 16'h0001, 1), 1, mk(RC_FULL, 0, 2));
        send_word(req(FUNC_ENQ, 1, 16'haaaa, 2), 1, mk(RC_OK, 0, 1));
        send_word(req(FUNC_ENQ, 1, 16'h5555, 3), 1, mk(RC_FULL, 0, 1));
        typed_active <= 1'b0;

        for (int p = 0; p < 6; p++) begin
            write_limit(limits[p]);
            calm = (p == 4);
            // first phase has no queue limit and the strongest enqueue bias, to fill the shared pool
            for (int k = 0; k < 80; k++) begin
                if (p == 2 && k == 40) drain();
                send_word(rand_word(enq_bias[p]), 0, none);
            end
        end
        calm = 1'b0;

        drain();
        repeat (20) @(posedge i_clk);
        $display("checked %0d results over six queue limits, %0d refusals, %0d misses",
                 n_checked, n_full, n_notfound);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
